// File: design/plist_pkg.sv
// plist_pkg: shared types and constants for the positional list engine
// no dependencies; imported by plist_cell, plist_ctrl and the top level
`default_nettype none

package plist_pkg;

   // default list capacity and fixed field widths
   localparam int unsigned PLIST_DEPTH = 128;
   localparam int unsigned REC_W       = 64;   // id in [31:0], score bits in [63:32]
   localparam int unsigned IDX_W       = 12;   // cell index, enough for the largest list
   localparam int unsigned GRP         = 16;   // cells per first-level read group
   localparam int unsigned REQ_W       = 80;
   localparam int unsigned RSP_W       = 80;

   // request operation codes
   typedef enum logic [1:0] {
      OP_READ    = 2'd0,
      OP_INSERT  = 2'd1,
      OP_DELETE  = 2'd2,
      OP_REPLACE = 2'd3
   } op_type;

   // response status codes
   typedef enum logic [1:0] {
      STAT_OK    = 2'd0,
      STAT_RANGE = 2'd1,
      STAT_FULL  = 2'd2
   } status_type;

   // controller sequencing
   typedef enum logic [1:0] {
      S_IDLE = 2'd0,
      S_EXEC = 2'd1,
      S_DONE = 2'd2
   } state_type;

   // command broadcast from the controller to every cell
   typedef struct packed {
      logic             ins;   // insert at pidx, cells above take their lower neighbour
      logic             del;   // delete at pidx, cells from pidx up take their upper neighbour
      logic             rep;   // overwrite the cell at pidx
      logic             cap;   // capture the selected record into the read groups
      logic [IDX_W-1:0] pidx;  // 0-based target cell
      logic [REC_W-1:0] data;  // record to write
   } cmd_type;

endpackage

`default_nettype wire

// File: design/plist_cell.sv
// plist_cell: one list slot of the cell row, holding a single record
// depends on plist_pkg (cmd_type, widths)
`default_nettype none

module plist_cell import plist_pkg::*; #(
   parameter int unsigned INDEX = 0
) (
   input  wire logic             clock,
   input  wire cmd_type          cmd,
   input  wire logic [REC_W-1:0] left_rec,   // record of the cell one place lower
   input  wire logic [REC_W-1:0] right_rec,  // record of the cell one place higher
   output logic      [REC_W-1:0] rec,
   output logic      [REC_W-1:0] sel_rec     // own record when addressed, else zero
);

   logic [REC_W-1:0] rec_ff;
   logic [REC_W-1:0] rec_in;
   logic             hit;
   logic             above;

   // position of this cell relative to the target
   assign hit   = (cmd.pidx == IDX_W'(INDEX));
   assign above = (IDX_W'(INDEX) > cmd.pidx);

   // next record: shift, write or hold
   always_comb begin
      rec_in = rec_ff;
      if (cmd.ins) begin
         if (hit) begin
            rec_in = cmd.data;
         end else if (above) begin
            rec_in = left_rec;
         end
      end else if (cmd.del) begin
         if (hit || above) begin
            rec_in = right_rec;
         end
      end else if (cmd.rep && hit) begin
         rec_in = cmd.data;
      end
   end

   // payload storage, no reset
   always_ff @(posedge clock) begin
      rec_ff <= rec_in;
   end

   assign rec     = rec_ff;
   assign sel_rec = hit ? rec_ff : '0;

endmodule

`default_nettype wire

// File: design/plist_ctrl.sv
// plist_ctrl: request decode, length count, sequencing and response register
// depends on plist_pkg (op/status/state codes, cmd_type)
`default_nettype none

module plist_ctrl import plist_pkg::*; #(
   parameter int unsigned DEPTH = PLIST_DEPTH
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_tvalid,
   output logic                  req_tready,
   input  wire logic [REQ_W-1:0] req_tdata,
   output logic                  rsp_tvalid,
   input  wire logic             rsp_tready,
   output logic      [RSP_W-1:0] rsp_tdata,
   output cmd_type               cmd,
   input  wire logic [REC_W-1:0] read_rec    // record picked out by the read groups
);

   localparam int unsigned CW   = $clog2(DEPTH + 1);
   localparam int unsigned CMPW = (CW > 8) ? CW + 1 : 9;

   state_type        state_ff, state_in;
   op_type           op_ff;
   logic [7:0]       pos_ff;
   logic [REC_W-1:0] data_ff;
   logic [CW-1:0]    count_ff, count_in;
   status_type       status_ff, status_in;
   logic             keep_ff, keep_in;
   logic             rsp_valid_ff;
   logic [RSP_W-1:0] rsp_data_ff;

   logic [CMPW-1:0]  pos_ext;
   logic [CMPW-1:0]  cnt_ext;
   logic             pos_ok;
   logic             full;
   logic             done_ok;
   logic             do_ins, do_del, do_rep;
   logic [REC_W-1:0] out_rec;

   // position checks against the current length
   assign pos_ext = CMPW'(pos_ff);
   assign cnt_ext = CMPW'(count_ff);
   assign full    = (count_ff == CW'(DEPTH));

   always_comb begin
      if (op_ff == OP_INSERT) begin
         pos_ok = (pos_ext != '0) && (pos_ext <= cnt_ext + CMPW'(1));
      end else begin
         pos_ok = (pos_ext != '0) && (pos_ext <= cnt_ext);
      end
   end

   // operation outcome
   always_comb begin
      status_in = STAT_OK;
      do_ins    = 1'b0;
      do_del    = 1'b0;
      do_rep    = 1'b0;
      keep_in   = 1'b0;
      count_in  = count_ff;
      if (!pos_ok) begin
         status_in = STAT_RANGE;
      end else begin
         case (op_ff)
            OP_INSERT: begin
               if (full) begin
                  status_in = STAT_FULL;
               end else begin
                  do_ins   = 1'b1;
                  count_in = count_ff + CW'(1);
               end
            end
            OP_DELETE: begin
               do_del   = 1'b1;
               keep_in  = 1'b1;
               count_in = count_ff - CW'(1);
            end
            OP_REPLACE: begin
               do_rep = 1'b1;
            end
            default: begin
               keep_in = 1'b1;
            end
         endcase
      end
   end

   assign done_ok = !rsp_valid_ff || rsp_tready;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: if (req_tvalid) state_in = S_EXEC;
         S_EXEC: state_in = S_DONE;
         S_DONE: if (done_ok) state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   // state outputs
   always_comb begin
      req_tready = 1'b0;
      cmd        = '0;
      case (state_ff)
         S_IDLE: req_tready = 1'b1;
         S_EXEC: begin
            cmd.ins = do_ins;
            cmd.del = do_del;
            cmd.rep = do_rep;
            cmd.cap = 1'b1;
         end
         S_DONE: ;
         default: ;
      endcase
      cmd.pidx = IDX_W'(pos_ext - CMPW'(1));
      cmd.data = data_ff;
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (state_ff == S_EXEC) begin
            count_ff <= count_in;
         end
         if (state_ff == S_DONE && done_ok) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign out_rec = keep_ff ? read_rec : '0;

   // request and response payload
   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         op_ff   <= op_type'(req_tdata[1:0]);
         pos_ff  <= req_tdata[9:2];
         data_ff <= {req_tdata[73:42], req_tdata[41:10]};
      end
      if (state_ff == S_EXEC) begin
         status_ff <= status_in;
         keep_ff   <= keep_in;
      end
      if (state_ff == S_DONE && done_ok) begin
         rsp_data_ff <= {6'd0, 8'(count_ff), out_rec[63:32], out_rec[31:0], status_ff};
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // length never passes the capacity
   a_count_cap: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(DEPTH))
      else $error("list length above capacity");

   // at most one shifting or writing command at a time
   a_cmd_one: assert property (@(posedge clock) disable iff (reset)
      $onehot0({cmd.ins, cmd.del, cmd.rep}))
      else $error("conflicting cell commands");

   // an insert grows the list by one
   a_ins_len: assert property (@(posedge clock) disable iff (reset)
      cmd.ins |=> count_ff == $past(count_ff) + CW'(1))
      else $error("insert did not grow the list");

   // a delete shrinks the list by one
   a_del_len: assert property (@(posedge clock) disable iff (reset)
      cmd.del |=> count_ff == $past(count_ff) - CW'(1))
      else $error("delete did not shrink the list");

endmodule

`default_nettype wire

// File: design/positional_list_engine_core.sv
// positional_list_engine_core: top level, a row of record cells with a grouped read select
// depends on plist_pkg, plist_cell and plist_ctrl
//
//   channel | direction | handshake           | payload
//   req     | in        | req_tvalid/tready   | func, position, entry_id, entry_score_bits
//   rsp     | out       | rsp_tvalid/tready   | status, out_id, out_score_bits, list_length
//
// each request goes through three steps: accept, execute in the cell row, then the read
// select reduces its registered groups into the response register; the next request
// is taken once the previous result is in the response register.
// every cell shifts in the same cycle, so insert and delete cost no more than read.
// reset clears the length and control only; record contents are undefined until written.
// a stalled response holds the block in its last step until rsp_tready frees the register.
`default_nettype none

module positional_list_engine_core import plist_pkg::*; #(
   parameter int unsigned DEPTH = PLIST_DEPTH
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_tvalid,
   output logic                  req_tready,
   input  wire logic [REQ_W-1:0] req_tdata,  // func[1:0], position[9:2], entry_id[41:10],
                                             // entry_score_bits[73:42], zero[79:74]
   output logic                  rsp_tvalid,
   input  wire logic             rsp_tready,
   output logic      [RSP_W-1:0] rsp_tdata   // status[1:0], out_id[33:2],
                                             // out_score_bits[65:34], list_length[73:66],
                                             // zero[79:74]
);

   localparam int unsigned NGRP = (DEPTH + GRP - 1) / GRP;

   cmd_type          cmd;
   logic [REC_W-1:0] recs [DEPTH];
   logic [REC_W-1:0] sels [DEPTH];
   logic [REC_W-1:0] grp_ff [NGRP];
   logic [REC_W-1:0] read_rec;

   // sequencing and response
   plist_ctrl #(
      .DEPTH (DEPTH)
   ) u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .cmd        (cmd),
      .read_rec   (read_rec)
   );

   // row of record cells, each wired to its two neighbours
   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      logic [REC_W-1:0] left_rec;
      logic [REC_W-1:0] right_rec;

      if (i == 0) begin : g_first
         assign left_rec = '0;
      end else begin : g_mid_l
         assign left_rec = recs[i-1];
      end

      if (i == DEPTH - 1) begin : g_last
         assign right_rec = recs[i];
      end else begin : g_mid_r
         assign right_rec = recs[i+1];
      end

      plist_cell #(
         .INDEX (i)
      ) u_cell (
         .clock     (clock),
         .cmd       (cmd),
         .left_rec  (left_rec),
         .right_rec (right_rec),
         .rec       (recs[i]),
         .sel_rec   (sels[i])
      );
   end

   // first read level: merge each group of cells and register it
   for (genvar g = 0; g < NGRP; g++) begin : g_grp
      logic [REC_W-1:0] grp_or;

      always_comb begin
         grp_or = '0;
         for (int k = 0; k < GRP; k++) begin
            if (g * GRP + k < DEPTH) begin
               grp_or = grp_or | sels[g * GRP + k];
            end
         end
      end

      always_ff @(posedge clock) begin
         if (cmd.cap) begin
            grp_ff[g] <= grp_or;
         end
      end
   end

   // second read level: merge the registered groups
   always_comb begin
      read_rec = '0;
      for (int g = 0; g < NGRP; g++) begin
         read_rec = read_rec | grp_ff[g];
      end
   end

endmodule

`default_nettype wire
